### src/dqpm_pkg.sv
package dqpm_pkg;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Field widths on the stream ports.
  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int IN_FIELDS_W   = REQ_W + VALUE_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = VALUE_W + STATUS_W + COUNT_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_MAX    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd5;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

### src/dqpm_ram.sv
module dqpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/deque_with_pop_max.sv
// Bounded double-ended queue of signed words with a remove-largest request.
// Requests enter on the s_axis channel, one item per request; every request
// gives exactly one result item on the m_axis channel carrying the value
// popped or peeked (zero otherwise), a status (ok, empty, full) and the
// entry count after the request.
// The entries live in one RAM with a registered read port, organized as a
// circular buffer around a head pointer. One request is worked on at a time.
// A push, a refused or empty request and an unused code go straight to
// the output stage; a pop or peek front/back first makes one RAM read; a
// pop max makes one RAM read per entry for the scan, then one read/write
// per entry behind the removed maximum from the front to close the gap.
// The result waits in an output register. While the receiver stalls, one
// more request is taken and worked on, and its result then waits until the
// register is free; no further request is taken until then. Reset empties
// the queue and clears the output valid; RAM contents are not cleared.
module deque_with_pop_max
  import dqpm_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // req_type [2:0], push_value [34:3], zero [39:35]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_value [31:0], status [33:32], entry_count [38:34], zero [39]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_OUT
  } state_t;

  state_t              state;
  logic [AW-1:0]       head;
  logic [CW-1:0]       occ;
  logic [STATUS_W-1:0] status;
  logic [DATA_WIDTH-1:0] val;
  logic [CW-1:0]       ptr;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       best;
  logic [DATA_WIDTH-1:0] best_val;
  logic [CW-1:0]       wr_idx;

  logic                  in_accept;
  logic [REQ_W-1:0]      in_req;
  logic [DATA_WIDTH-1:0] in_value;

  logic                  ram_wr_en;
  logic                  ram_rd_en;
  logic [CW-1:0]         wr_logical;
  logic [CW-1:0]         rd_logical;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  better;
  logic [CW-1:0]         best_fin;
  logic [DATA_WIDTH-1:0] best_val_fin;
  logic                  scan_last;
  logic                  shift_last;
  logic [AW-1:0]         head_inc;
  logic [AW-1:0]         head_dec;
  logic [CW-1:0]         occ_m1;
  logic                  out_free;

  // Physical RAM address of a position counted from the front.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] lg);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(lg);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_req        = s_axis_tdata[REQ_W-1:0];
  assign in_value      = DATA_WIDTH'(64'($signed(s_axis_tdata[REQ_W +: VALUE_W])));

  assign occ_m1   = occ - CW'(1);
  assign head_inc = slot(head, CW'(1));
  assign head_dec = slot(head, CW'(DEPTH - 1));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Scan step: the first maximum from the front wins, so only a strictly
  // larger value replaces the current best.
  assign better       = (cnt == '0) || ($signed(rd_data) > $signed(best_val));
  assign best_fin     = better ? cnt : best;
  assign best_val_fin = better ? rd_data : best_val;
  assign scan_last    = (cnt == occ_m1);
  assign shift_last   = ((CW+1)'(wr_idx) + (CW+1)'(2)) >= (CW+1)'(occ);

  always_comb begin
    ram_wr_en  = 1'b0;
    ram_rd_en  = 1'b0;
    wr_logical = occ;
    rd_logical = '0;
    wr_data    = in_value;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (in_req)
            REQ_PUSH_FRONT: begin
              ram_wr_en  = (occ != CW'(DEPTH));
              wr_logical = CW'(DEPTH - 1);
            end
            REQ_PUSH_BACK: begin
              ram_wr_en  = (occ != CW'(DEPTH));
              wr_logical = occ;
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT, REQ_POP_MAX: begin
              ram_rd_en  = (occ != '0);
              rd_logical = '0;
            end
            REQ_POP_BACK, REQ_PEEK_BACK: begin
              ram_rd_en  = (occ != '0);
              rd_logical = occ_m1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!scan_last) begin
          ram_rd_en  = (ptr < occ);
          rd_logical = ptr;
        end else if (best_fin != occ_m1) begin
          ram_rd_en  = 1'b1;
          rd_logical = best_fin + CW'(1);
        end
      end
      S_SHIFT: begin
        ram_wr_en  = 1'b1;
        wr_logical = wr_idx;
        wr_data    = rd_data;
        ram_rd_en  = !shift_last;
        rd_logical = wr_idx + CW'(2);
      end
      default: begin
      end
    endcase
  end

  assign wr_addr = slot(head, wr_logical);
  assign rd_addr = slot(head, rd_logical);

  dqpm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      occ           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            status <= STATUS_OK;
            val    <= '0;
            state  <= S_OUT;
            case (in_req)
              REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (occ == CW'(DEPTH)) begin
                  status <= STATUS_FULL;
                end else begin
                  occ <= occ + CW'(1);
                  if (in_req == REQ_PUSH_FRONT) begin
                    head <= head_dec;
                  end
                end
              end
              REQ_POP_FRONT, REQ_PEEK_FRONT, REQ_POP_BACK, REQ_PEEK_BACK: begin
                if (occ == '0) begin
                  status <= STATUS_EMPTY;
                end else begin
                  state <= S_READ;
                  // The read address is already formed, so the pointers
                  // can move now.
                  if (in_req == REQ_POP_FRONT) begin
                    head <= head_inc;
                    occ  <= occ_m1;
                  end else if (in_req == REQ_POP_BACK) begin
                    occ <= occ_m1;
                  end
                end
              end
              REQ_POP_MAX: begin
                if (occ == '0) begin
                  status <= STATUS_EMPTY;
                end else begin
                  state <= S_SCAN;
                  ptr   <= CW'(1);
                  cnt   <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          val   <= rd_data;
          state <= S_OUT;
        end
        S_SCAN: begin
          best     <= best_fin;
          best_val <= best_val_fin;
          cnt      <= cnt + CW'(1);
          ptr      <= ptr + CW'(1);
          if (scan_last) begin
            val <= best_val_fin;
            if (best_fin == occ_m1) begin
              occ   <= occ_m1;
              state <= S_OUT;
            end else begin
              wr_idx <= best_fin;
              state  <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          wr_idx <= wr_idx + CW'(1);
          if (shift_last) begin
            occ   <= occ_m1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_TDATA_W'({COUNT_W'(occ), status,
                                           VALUE_W'(64'($signed(val)))});
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dqpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 550;
  localparam int CAPACITY       = DEPTH_DEFAULT;
  // The request code that the block ignores.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } reply_t;

  typedef enum {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_mode_t;

  // Shadow copy of the deque; it predicts one reply per request and checks
  // the replies in order.
  class deque_mirror;
    logic signed [VALUE_W-1:0] store[CAPACITY];
    logic [3:0] head;
    logic [COUNT_W-1:0] count;
    reply_t expected_replies[$];
    int errors;

    function new();
      head   = '0;
      count  = '0;
      errors = 0;
    endfunction

    function logic [3:0] slot(int k);
      return head + k[3:0];
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void apply_request(logic [REQ_W-1:0] req, logic signed [VALUE_W-1:0] val);
      reply_t exp;
      int best;
      exp = '{value: '0, status: STATUS_OK, count: '0};
      case (req)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (count == CAPACITY) begin
            exp.status = STATUS_FULL;
          end else if (req == REQ_PUSH_FRONT) begin
            head = head - 4'd1;
            store[head] = val;
            count++;
          end else begin
            store[slot(count)] = val;
            count++;
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK, REQ_POP_MAX, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
          if (count == 0) begin
            exp.status = STATUS_EMPTY;
          end else if (req == REQ_POP_FRONT || req == REQ_PEEK_FRONT) begin
            exp.value = store[head];
            if (req == REQ_POP_FRONT) begin
              head = head + 4'd1;
              count--;
            end
          end else if (req == REQ_POP_BACK || req == REQ_PEEK_BACK) begin
            exp.value = store[slot(count - 1)];
            if (req == REQ_POP_BACK) count--;
          end else begin
            // Strictly greater keeps the maximum closest to the front.
            best = 0;
            for (int k = 1; k < count; k++) begin
              if (store[slot(k)] > store[slot(best)]) best = k;
            end
            exp.value = store[slot(best)];
            for (int k = best; k + 1 < count; k++) store[slot(k)] = store[slot(k + 1)];
            count--;
          end
        end
        default: ;
      endcase
      exp.count = count;
      expected_replies.push_back(exp);
    endfunction

    function void check_reply(logic [OUT_TDATA_W-1:0] d);
      reply_t exp;
      logic [VALUE_W-1:0]  got_value;
      logic [STATUS_W-1:0] got_status;
      logic [COUNT_W-1:0]  got_count;
      got_value  = d[VALUE_W-1:0];
      got_status = d[VALUE_W +: STATUS_W];
      got_count  = d[VALUE_W+STATUS_W +: COUNT_W];
      if (expected_replies.size() == 0) begin
        $error("reply with nothing expected: value %0d status %0d count %0d",
               $signed(got_value), got_status, got_count);
        errors++;
        return;
      end
      exp = expected_replies.pop_front();
      if (got_value !== exp.value) begin
        $error("out_value: expected %0d, got %0d", $signed(exp.value), $signed(got_value));
        errors++;
      end
      if (got_status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got_status);
        errors++;
      end
      if (got_count !== exp.count) begin
        $error("entry_count: expected %0d, got %0d", exp.count, got_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // req_type [2:0], push_value [34:3], zero [39:35]
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // out_value [31:0], status [33:32], entry_count [38:34], zero [39]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  deque_mirror mirror = new();
  bit calm = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  deque_with_pop_max DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      // A narrow range gives plenty of equal maxima.
      1, 2: return 32'($urandom_range(0, 8) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(phase_mode_t mode);
    int r;
    int push_pct;
    r = $urandom_range(0, 99);
    push_pct = (mode == FILL_PHASE) ? 70 : (mode == DRAIN_PHASE) ? 20 : 35;
    if (r < push_pct) return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    if ($urandom_range(0, 19) == 0) return REQ_UNUSED;
    return 3'($urandom_range(2, 6));
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, val, req};
    do @(posedge clk); while (!s_axis_tready);
    mirror.apply_request(req, val);
  endtask

  // Called right after an accepted item; a zero gap keeps tvalid high.
  task automatic rest_sender();
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  task automatic issue(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
    send_request(req, val);
    rest_sender();
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) mirror.check_reply(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    phase_mode_t mode;
    int sent;
    int phase_len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Requests on an empty deque, then the ignored code.
    issue(REQ_POP_FRONT, 32'h1234_5678);
    issue(REQ_POP_BACK, '0);
    issue(REQ_POP_MAX, '0);
    issue(REQ_PEEK_FRONT, '0);
    issue(REQ_PEEK_BACK, '0);
    issue(REQ_UNUSED, 32'hdead_beef);
    // Extremes, with two equal maxima; front holds -1, MIN, MAX, MAX, 0.
    issue(REQ_PUSH_BACK, 32'h7fff_ffff);
    issue(REQ_PUSH_FRONT, 32'h8000_0000);
    issue(REQ_PUSH_BACK, 32'h7fff_ffff);
    issue(REQ_PUSH_FRONT, 32'hffff_ffff);
    issue(REQ_PUSH_BACK, 32'h0000_0000);
    issue(REQ_PEEK_FRONT, '0);
    issue(REQ_PEEK_BACK, '0);
    issue(REQ_POP_MAX, '0);
    issue(REQ_POP_MAX, '0);
    issue(REQ_POP_FRONT, '0);
    issue(REQ_POP_BACK, '0);
    issue(REQ_POP_MAX, '0);
    issue(REQ_UNUSED, 32'hffff_ffff);
    wait_for_replies();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = phase_mode_t'($urandom_range(0, 2));
      calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 70);
      for (int i = 0; i < phase_len; i++) begin
        send_request(pick_request(mode), pick_value());
        sent++;
        if (i == phase_len - 1 && $urandom_range(0, 2) == 0) begin
          wait_for_replies();
        end else begin
          rest_sender();
        end
      end
    end

    calm = 1'b0;
    wait_for_replies();
    repeat (50) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/dqpm_pkg.sv
src/dqpm_ram.sv
src/deque_with_pop_max.sv
test/tb_top.sv
